// File: rtl/pid_velocity_command_limiter_defines.svh
// Assertion macros for the velocity command limiter.
// No dependencies; included by modules that carry assertions.
`ifndef PID_VELOCITY_COMMAND_LIMITER_DEFINES_SVH
`define PID_VELOCITY_COMMAND_LIMITER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("violated");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: rtl/pvcl_pkg.sv
// Shared types, constants and saturating helpers for the velocity command limiter.
// No dependencies.
package pvcl_pkg;
    localparam logic signed [31:0] MAX_CORRECTION = 32'sd1073741824;
    localparam logic [23:0] MIN_DT = 24'd17;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // Register indexes.
    localparam logic [2:0] REG_PID_ENABLE = 3'd0;
    localparam logic [2:0] REG_GAIN_P     = 3'd1;
    localparam logic [2:0] REG_GAIN_I     = 3'd2;
    localparam logic [2:0] REG_GAIN_D     = 3'd3;
    localparam logic [2:0] REG_FF_GAIN    = 3'd4;
    localparam logic [2:0] REG_INT_LIMIT  = 3'd5;
    localparam logic [2:0] REG_MAX_VEL    = 3'd6;
    localparam logic [2:0] REG_MAX_ACCEL  = 3'd7;

    // Multiplier result shift select.
    typedef enum logic [0:0] {
        t_SHIFT16 = 1'b0,
        t_SHIFT24 = 1'b1
    } t_mul_shift;

    typedef struct packed {
        logic              start;
        t_mul_shift        shift;
        logic signed [32:0] a;
        logic signed [32:0] b;
    } t_mul_req;

    // Saturate a 34-bit value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = S32_MAX;
        end else if (v < -34'sh0_8000_0000) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Symmetric clamp against a nonnegative limit.
    function automatic logic signed [33:0] clampsym(input logic signed [33:0] v,
                                                    input logic [30:0] lim);
        logic signed [33:0] l;
        logic signed [33:0] r;
        l = $signed({3'b000, lim});
        if (v > l) begin
            r = l;
        end else if (v < -l) begin
            r = -l;
        end else begin
            r = v;
        end
        return r;
    endfunction
endpackage

// File: rtl/pvcl_mul.sv
// Shared multiplier with rounding right shift and 32-bit saturation.
// Depends on pvcl_pkg; one product per request, product and result both registered.
`include "pid_velocity_command_limiter_defines.svh"
module pvcl_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pvcl_pkg::t_mul_req   i_req,
    output logic                 o_done,
    output logic signed [31:0]   o_result
);
    logic signed [65:0] r_prod;
    pvcl_pkg::t_mul_shift r_shift;
    logic r_prod_vld;
    logic signed [65:0] n_round;
    logic signed [33:0] n_shifted;

    // Stage one registers the raw product, stage two the saturated result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            r_prod_vld <= i_req.start;
            o_done     <= r_prod_vld;
        end
        r_prod  <= i_req.a * i_req.b;
        r_shift <= i_req.shift;
        o_result <= pvcl_pkg::sat32(n_shifted);
    end

    // Add half an LSB and floor-shift, which rounds ties toward plus infinity.
    always_comb begin
        if (r_shift == pvcl_pkg::t_SHIFT24) begin
            n_round   = r_prod + 66'sd8388608;
            n_shifted = (n_round >>> 24) > 66'sh1_FFFF_FFFF ? 34'sh1_FFFF_FFFF :
                        (n_round >>> 24) < -66'sh2_0000_0000 ? -34'sh2_0000_0000 :
                        34'(n_round >>> 24);
        end else begin
            n_round   = r_prod + 66'sd32768;
            n_shifted = (n_round >>> 16) > 66'sh1_FFFF_FFFF ? 34'sh1_FFFF_FFFF :
                        (n_round >>> 16) < -66'sh2_0000_0000 ? -34'sh2_0000_0000 :
                        34'(n_round >>> 16);
        end
    end

    `ASSERT_IMPL(a_done_follows, i_clk, i_rst_n, i_req.start |-> ##2 o_done)
    `ASSERT_NEVER(a_no_early_done, i_clk, i_rst_n, o_done && !$past(r_prod_vld))
    `ASSERT_IMPL(a_pipe, i_clk, i_rst_n, r_prod_vld |-> $past(i_req.start))
endmodule

// File: rtl/pvcl_cfg.sv
// APB register file holding gains and limits.
// Depends on pvcl_pkg for register indexes.
module pvcl_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_pid_enable,
    output logic signed [31:0] o_gain_p,
    output logic signed [31:0] o_gain_i,
    output logic signed [31:0] o_gain_d,
    output logic signed [31:0] o_ff_gain,
    output logic [30:0] o_integral_limit,
    output logic [30:0] o_max_velocity,
    output logic [30:0] o_max_accel
);
    logic [2:0] n_idx;
    logic       n_wr;

    assign pready = 1'b1;
    assign n_idx  = paddr[4:2];
    assign n_wr   = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pid_enable     <= 1'b0;
            o_gain_p         <= '0;
            o_gain_i         <= '0;
            o_gain_d         <= '0;
            o_ff_gain        <= '0;
            o_integral_limit <= '0;
            o_max_velocity   <= '0;
            o_max_accel      <= '0;
        end else if (n_wr) begin
            case (n_idx)
                pvcl_pkg::REG_PID_ENABLE: o_pid_enable     <= pwdata[0];
                pvcl_pkg::REG_GAIN_P:     o_gain_p         <= pwdata;
                pvcl_pkg::REG_GAIN_I:     o_gain_i         <= pwdata;
                pvcl_pkg::REG_GAIN_D:     o_gain_d         <= pwdata;
                pvcl_pkg::REG_FF_GAIN:    o_ff_gain        <= pwdata;
                pvcl_pkg::REG_INT_LIMIT:  o_integral_limit <= pwdata[30:0];
                pvcl_pkg::REG_MAX_VEL:    o_max_velocity   <= pwdata[30:0];
                pvcl_pkg::REG_MAX_ACCEL:  o_max_accel      <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (n_idx)
            pvcl_pkg::REG_PID_ENABLE: prdata = {31'd0, o_pid_enable};
            pvcl_pkg::REG_GAIN_P:     prdata = o_gain_p;
            pvcl_pkg::REG_GAIN_I:     prdata = o_gain_i;
            pvcl_pkg::REG_GAIN_D:     prdata = o_gain_d;
            pvcl_pkg::REG_FF_GAIN:    prdata = o_ff_gain;
            pvcl_pkg::REG_INT_LIMIT:  prdata = {1'b0, o_integral_limit};
            pvcl_pkg::REG_MAX_VEL:    prdata = {1'b0, o_max_velocity};
            pvcl_pkg::REG_MAX_ACCEL:  prdata = {1'b0, o_max_accel};
            default:                  prdata = '0;
        endcase
    end
endmodule

// File: rtl/pid_velocity_command_limiter.sv
// Top level: stream ports, sequencer and state of the velocity command limiter.
// Depends on pvcl_pkg, pvcl_cfg and pvcl_mul.
//
//   channel  | dir | payload
//   s_axis   | in  | op (tuser), error, ff, ref, act, cdt, fdt, fresh, init (tdata)
//   m_axis   | out | command, raw, p, i, d, ff terms (tdata); flags (tuser)
//   apb      | in  | eight registers at byte address 4*i
//
// Products pass one after another through the shared two-stage multiplier. An
// update word visits S_INT and S_INTW only on fresh feedback and S_INT to S_D
// only with PID enabled; anti-windup adds a pass through S_AW, S_AWW and S_SUM.
// A reset op skips to S_OUT. The input is ready in the idle state only, and a
// finished word waits in S_OUT while the previous result is still unaccepted.
// Reset is synchronous and clears the integral and the last command.
`include "pid_velocity_command_limiter_defines.svh"
module pid_velocity_command_limiter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // error[31:0] ff[63:32] ref[95:64] act[127:96] cdt[151:128] fdt[175:152]
    // fresh[176] init[208:177], zero filled
    input  logic [215:0] s_axis_tdata,
    // op[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // command[31:0] raw[63:32] p[95:64] i[127:96] d[159:128] ff[191:160]
    output logic [191:0] m_axis_tdata,
    // integral_frozen[0] velocity_saturated[1] accel_limited[2]
    output logic [2:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    typedef enum logic [3:0] {
        S_IDLE, S_FF, S_INT, S_INTW, S_P, S_I, S_D, S_DW, S_SUM, S_AW, S_AWW,
        S_SLEW, S_SLEWW, S_OUT
    } t_state;

    // Destination of each product, carried alongside the multiplier pipeline.
    typedef enum logic [2:0] {
        D_NONE, D_FF, D_INT, D_P, D_I, D_D, D_STEP
    } t_dst;

    logic cfg_en;
    logic signed [31:0] cfg_gp, cfg_gi, cfg_gd, cfg_gff;
    logic [30:0] cfg_ilim, cfg_vmax, cfg_amax;

    pvcl_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_pid_enable(cfg_en), .o_gain_p(cfg_gp), .o_gain_i(cfg_gi), .o_gain_d(cfg_gd),
        .o_ff_gain(cfg_gff), .o_integral_limit(cfg_ilim), .o_max_velocity(cfg_vmax),
        .o_max_accel(cfg_amax)
    );

    t_state r_state;
    logic signed [31:0] r_err, r_ffv, r_dv, r_int, r_prev_int, r_last;
    logic [23:0] r_cdt, r_fdt;
    logic r_fresh;
    logic signed [31:0] r_p, r_i, r_d, r_ff, r_raw, r_vlim, r_cmd;
    logic r_frozen, r_vsat, r_alim;
    logic [2:0] r_mcnt;
    t_dst r_dst1, r_dst2;
    t_dst n_dst;
    logic [191:0] r_out_data;
    logic [2:0]   r_out_user;
    logic n_out_free;
    logic n_last;

    pvcl_pkg::t_mul_req n_req;
    logic mul_done;
    logic signed [31:0] mul_res;

    pvcl_mul u_mul (.i_clk, .i_rst_n, .i_req(n_req), .o_done(mul_done), .o_result(mul_res));

    logic signed [33:0] n_pid, n_raw34, n_step, n_cmd34;
    logic signed [31:0] n_raw, n_vlim;
    logic n_aw;

    assign s_axis_tready = (r_state == S_IDLE);
    assign n_out_free    = !m_axis_tvalid || m_axis_tready;
    // The last outstanding product is back when nothing follows it in the pipe.
    assign n_last        = mul_done && (r_dst1 == D_NONE);

    // Correction sum and clamps.
    always_comb begin
        n_pid   = 34'(r_p) + 34'(r_i) + 34'(r_d);
        n_raw34 = 34'(r_ff) + pvcl_pkg::clampsym(n_pid, pvcl_pkg::MAX_CORRECTION[30:0]);
        n_raw   = pvcl_pkg::sat32(n_raw34);
        n_vlim  = 32'(pvcl_pkg::clampsym(34'(n_raw), cfg_vmax));
        n_aw    = (n_vlim != n_raw) && cfg_en &&
                  ((r_err > 0 && n_raw > 0) || (r_err < 0 && n_raw < 0));
        n_step  = pvcl_pkg::clampsym(34'(r_vlim) - 34'(r_last), mul_res[30:0]);
        n_cmd34 = 34'(r_last) + n_step;
    end

    // Multiplier requests.
    always_comb begin
        n_req.start = 1'b0;
        n_req.shift = pvcl_pkg::t_SHIFT16;
        n_req.a     = 33'(cfg_gff);
        n_req.b     = 33'(r_ffv);
        n_dst       = D_NONE;
        case (r_state)
            S_FF: begin
                n_req.start = 1'b1; n_dst = D_FF;
            end
            S_INT: begin
                n_req.start = 1'b1; n_req.shift = pvcl_pkg::t_SHIFT24;
                n_req.a = 33'(r_err); n_req.b = $signed({9'd0, r_fdt}); n_dst = D_INT;
            end
            S_P: begin
                n_req.start = 1'b1; n_req.a = 33'(cfg_gp); n_req.b = 33'(r_err);
                n_dst = D_P;
            end
            S_I, S_AW: begin
                n_req.start = 1'b1; n_req.a = 33'(cfg_gi); n_req.b = 33'(r_int);
                n_dst = D_I;
            end
            S_D: begin
                n_req.start = 1'b1; n_req.a = 33'(cfg_gd); n_req.b = 33'(r_dv);
                n_dst = D_D;
            end
            S_SLEW: begin
                n_req.start = 1'b1; n_req.shift = pvcl_pkg::t_SHIFT24;
                n_req.a = $signed({2'b00, cfg_amax}); n_req.b = $signed({9'd0, r_cdt});
                n_dst = D_STEP;
            end
            default: ;
        endcase
    end

    // Sequencer and state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_int <= '0;
            r_last <= '0;
            m_axis_tvalid <= 1'b0;
            r_mcnt <= '0;
            r_dst1 <= D_NONE;
            r_dst2 <= D_NONE;
        end else begin
            r_dst1 <= n_dst;
            r_dst2 <= r_dst1;

            // Output word handshake.
            if (r_state == S_OUT && n_out_free) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end

            // Each product lands in its destination as it leaves the multiplier.
            if (mul_done) begin
                case (r_dst2)
                    D_FF:  r_ff <= mul_res;
                    D_INT: r_int <= 32'(pvcl_pkg::clampsym(
                               34'(pvcl_pkg::sat32(34'(r_int) + 34'(mul_res))), cfg_ilim));
                    D_P:   r_p <= mul_res;
                    D_I:   r_i <= mul_res;
                    D_D:   r_d <= mul_res;
                    D_STEP: begin
                        r_cmd  <= pvcl_pkg::sat32(n_cmd34);
                        r_alim <= pvcl_pkg::sat32(n_cmd34) != r_vlim;
                        r_last <= pvcl_pkg::sat32(n_cmd34);
                    end
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_err <= s_axis_tdata[31:0];
                    r_ffv <= s_axis_tdata[63:32];
                    r_dv  <= pvcl_pkg::sat32(34'($signed(s_axis_tdata[95:64])) -
                                             34'($signed(s_axis_tdata[127:96])));
                    r_cdt <= (s_axis_tdata[151:128] < pvcl_pkg::MIN_DT) ?
                             pvcl_pkg::MIN_DT : s_axis_tdata[151:128];
                    r_fdt <= (s_axis_tdata[175:152] < pvcl_pkg::MIN_DT) ?
                             pvcl_pkg::MIN_DT : s_axis_tdata[175:152];
                    r_fresh <= s_axis_tdata[176];
                    r_prev_int <= r_int;
                    r_p <= '0; r_i <= '0; r_d <= '0; r_frozen <= 1'b0;
                    if (s_axis_tuser) begin
                        r_int <= '0;
                        r_last <= s_axis_tdata[208:177];
                        r_cmd <= s_axis_tdata[208:177];
                        r_raw <= '0; r_ff <= '0; r_vsat <= 1'b0; r_alim <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_FF;
                    end
                end
                S_FF: begin
                    r_mcnt <= '0;
                    r_state <= !cfg_en ? S_DW : (r_fresh ? S_INT : S_P);
                    if (cfg_en && !r_fresh) r_frozen <= 1'b1;
                end
                S_INT: r_state <= S_INTW;
                S_INTW: if (n_last) r_state <= S_P;
                S_P: r_state <= S_I;
                S_I: r_state <= S_D;
                S_D: r_state <= S_DW;
                S_DW: if (n_last) r_state <= S_SUM;
                S_SUM: begin
                    r_raw <= n_raw; r_vlim <= n_vlim; r_vsat <= (n_vlim != n_raw);
                    if (n_aw && r_mcnt != 3'd4) begin
                        r_int <= r_prev_int; r_frozen <= 1'b1; r_state <= S_AW;
                    end else begin
                        r_state <= S_SLEW;
                    end
                end
                S_AW: r_state <= S_AWW;
                S_AWW: if (n_last) begin
                    r_mcnt <= 3'd4; r_state <= S_SUM;
                end
                S_SLEW: r_state <= S_SLEWW;
                S_SLEWW: if (n_last) r_state <= S_OUT;
                S_OUT: if (n_out_free) begin
                    r_out_data <= {r_ff, r_d, r_i, r_p, r_raw, r_cmd};
                    r_out_user <= {r_alim, r_vsat, r_frozen};
                    r_mcnt <= '0; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = r_out_data;
    assign m_axis_tuser = r_out_user;

    `ASSERT_NEVER(a_busy_not_ready, i_clk, i_rst_n, s_axis_tready && r_state != S_IDLE)
    `ASSERT_IMPL(a_out_from_seq, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(r_state == S_OUT))
    `ASSERT_IMPL(a_aw_once, i_clk, i_rst_n, (r_state == S_AW) |-> r_frozen)
endmodule
